[sv/frr_pkg.sv]
// ----------------------------------------------------------------------------
// First-match range recoder: shared definitions
// Field widths, rule kinds, register indexes and the beat structures that
// pass between the pipeline stages.
// ----------------------------------------------------------------------------
package frr_pkg;

   localparam int RULES_DEFAULT = 16;
   // Rules are resolved in groups of this size; GROUP_IDX_W sets the hit_rule width.
   localparam int GROUP_SIZE    = 16;
   localparam int GROUP_IDX_W   = 4;
   localparam int DATA_W        = 32;
   localparam int INDEX_W       = 4;
   localparam int KIND_W        = 3;
   localparam int COUNT_W       = 5;
   localparam int REQ_TDATA_W   = 144;
   localparam int RSP_TDATA_W   = 40;
   localparam int CSR_INDEX_W   = 1;
   localparam int CSR_DATA_W    = 5;

   localparam logic signed [DATA_W-1:0] SYSMIS = 32'sh8000_0000;

   typedef enum logic [KIND_W-1:0] {
      KIND_SINGLE  = 3'd0,
      KIND_RANGE   = 3'd1,
      KIND_SYSMIS  = 3'd2,
      KIND_MISSING = 3'd3,
      KIND_ELSE    = 3'd4
   } kind_type;

   typedef enum logic {
      ACT_WRITE  = 1'b0,
      ACT_RECODE = 1'b1
   } action_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_RULE_COUNT = 1'b0,
      CSR_SEPARATE   = 1'b1
   } csr_index_type;

   typedef struct packed {
      action_type                action;
      logic [INDEX_W-1:0]        rule_index;
      logic [KIND_W-1:0]         rule_kind;
      logic signed [DATA_W-1:0]  low_bound;
      logic signed [DATA_W-1:0]  high_bound;
      logic                      copy_sample;
      logic signed [DATA_W-1:0]  out_constant;
      logic signed [DATA_W-1:0]  sample;
      logic                      is_user_missing;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0]  result_value;
      logic                      write_dest;
      logic                      matched;
      logic [GROUP_IDX_W-1:0]    hit_rule;
   } rsp_type;

endpackage

[sv/frr_match.sv]
// ----------------------------------------------------------------------------
// Rule table and match stage
// Holds the rule entries, applies rule writes as they pass, and tests every
// rule in use against the sample of a recode beat.
// ----------------------------------------------------------------------------
module frr_match #(
   parameter int RULES = frr_pkg::RULES_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 in_valid,
   output logic                                 in_ready,
   input  frr_pkg::req_type                     in_data,
   input  logic [frr_pkg::COUNT_W-1:0]          rule_count,
   output logic                                 out_valid,
   input  logic                                 out_ready,
   output logic [RULES-1:0]                     out_match,
   output logic signed [frr_pkg::DATA_W-1:0]    out_sample,
   output logic                                 copy_tab [RULES],
   output logic signed [frr_pkg::DATA_W-1:0]    const_tab [RULES]
);

   logic [frr_pkg::KIND_W-1:0]         kind_ff  [RULES];
   logic signed [frr_pkg::DATA_W-1:0]  low_ff   [RULES];
   logic signed [frr_pkg::DATA_W-1:0]  high_ff  [RULES];
   logic                               copy_ff  [RULES];
   logic signed [frr_pkg::DATA_W-1:0]  const_ff [RULES];

   logic                               valid_ff, valid_in;
   logic [RULES-1:0]                   match_ff, match_in;
   logic signed [frr_pkg::DATA_W-1:0]  sample_ff, sample_in;
   logic [RULES-1:0]                   kind_hit;
   logic                               advance, is_recode, is_write;

   assign in_ready  = !valid_ff || out_ready;
   assign advance   = in_valid && in_ready;
   assign is_recode = (in_data.action == frr_pkg::ACT_RECODE);
   // Writes beyond the table are dropped here.
   assign is_write  = advance && !is_recode && (int'(in_data.rule_index) < RULES);

   always_comb begin
      for (int r = 0; r < RULES; r++) begin
         case (kind_ff[r])
            frr_pkg::KIND_SINGLE:  kind_hit[r] = (in_data.sample == low_ff[r]);
            frr_pkg::KIND_RANGE:   kind_hit[r] = (low_ff[r] <= in_data.sample) &&
                                                 (in_data.sample <= high_ff[r]);
            frr_pkg::KIND_SYSMIS:  kind_hit[r] = (in_data.sample == frr_pkg::SYSMIS);
            frr_pkg::KIND_MISSING: kind_hit[r] = in_data.is_user_missing ||
                                                 (in_data.sample == frr_pkg::SYSMIS);
            frr_pkg::KIND_ELSE:    kind_hit[r] = 1'b1;
            default:               kind_hit[r] = 1'b0;
         endcase
         // Rules at or past the count in use never match; a count above the
         // table size therefore acts as the full table.
         match_in[r] = kind_hit[r] && (int'(rule_count) > r);
      end
   end

   always_comb begin
      valid_in  = valid_ff;
      sample_in = sample_ff;
      if (in_ready) begin
         valid_in = in_valid && is_recode;
      end
      if (advance && is_recode) begin
         sample_in = in_data.sample;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sample_ff <= sample_in;
      if (advance && is_recode) begin
         match_ff <= match_in;
      end
   end

   // Table entries are written as the write beat leaves the input register,
   // so earlier recode beats have already taken their match vector.
   always_ff @(posedge clock) begin
      for (int r = 0; r < RULES; r++) begin
         if (is_write && (int'(in_data.rule_index) == r)) begin
            kind_ff[r]  <= in_data.rule_kind;
            low_ff[r]   <= in_data.low_bound;
            high_ff[r]  <= in_data.high_bound;
            copy_ff[r]  <= in_data.copy_sample;
            const_ff[r] <= in_data.out_constant;
         end
      end
   end

   assign out_valid  = valid_ff;
   assign out_match  = match_ff;
   assign out_sample = sample_ff;

   always_comb begin
      for (int r = 0; r < RULES; r++) begin
         copy_tab[r]  = copy_ff[r];
         const_tab[r] = const_ff[r];
      end
   end

endmodule

[sv/frr_group.sv]
// ----------------------------------------------------------------------------
// Group resolve stage
// Finds the first matching rule inside each group of sixteen and picks that
// rule's output value.
// ----------------------------------------------------------------------------
module frr_group #(
   parameter  int RULES      = frr_pkg::RULES_DEFAULT,
   localparam int GroupCount = (RULES + frr_pkg::GROUP_SIZE - 1) / frr_pkg::GROUP_SIZE
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 in_valid,
   output logic                                 in_ready,
   input  logic [RULES-1:0]                     in_match,
   input  logic signed [frr_pkg::DATA_W-1:0]    in_sample,
   input  logic                                 copy_tab [RULES],
   input  logic signed [frr_pkg::DATA_W-1:0]    const_tab [RULES],
   output logic                                 out_valid,
   input  logic                                 out_ready,
   output logic [GroupCount-1:0]                out_hit,
   output logic [frr_pkg::GROUP_IDX_W-1:0]      out_idx [GroupCount],
   output logic signed [frr_pkg::DATA_W-1:0]    out_val [GroupCount]
);

   localparam int PadRules   = GroupCount * frr_pkg::GROUP_SIZE;

   logic                               valid_ff, valid_in;
   logic [GroupCount-1:0]              hit_ff, hit_in;
   logic [frr_pkg::GROUP_IDX_W-1:0]    idx_ff [GroupCount];
   logic [frr_pkg::GROUP_IDX_W-1:0]    idx_in [GroupCount];
   logic signed [frr_pkg::DATA_W-1:0]  val_ff [GroupCount];
   logic signed [frr_pkg::DATA_W-1:0]  val_in [GroupCount];
   logic [PadRules-1:0]                match_pad;
   logic signed [frr_pkg::DATA_W-1:0]  rule_val [PadRules];
   logic [frr_pkg::GROUP_SIZE-1:0]     grp_vec   [GroupCount];
   logic [frr_pkg::GROUP_SIZE-1:0]     grp_first [GroupCount];
   logic                               advance;

   assign in_ready = !valid_ff || out_ready;
   assign advance  = in_valid && in_ready;

   always_comb begin
      for (int r = 0; r < PadRules; r++) begin
         if (r < RULES) begin
            match_pad[r] = in_match[r];
            rule_val[r]  = copy_tab[r] ? in_sample : const_tab[r];
         end else begin
            match_pad[r] = 1'b0;
            rule_val[r]  = '0;
         end
      end
   end

   // The lowest set bit of each group is isolated by an and with its
   // two's complement.
   always_comb begin
      for (int g = 0; g < GroupCount; g++) begin
         grp_vec[g]   = match_pad[g*frr_pkg::GROUP_SIZE +: frr_pkg::GROUP_SIZE];
         grp_first[g] = grp_vec[g] & (~grp_vec[g] + frr_pkg::GROUP_SIZE'(1));
         hit_in[g]    = |grp_vec[g];
         idx_in[g]    = '0;
         val_in[g]    = '0;
         for (int j = 0; j < frr_pkg::GROUP_SIZE; j++) begin
            if (grp_first[g][j]) begin
               idx_in[g] = idx_in[g] | frr_pkg::GROUP_IDX_W'(j);
               val_in[g] = val_in[g] | rule_val[g*frr_pkg::GROUP_SIZE + j];
            end
         end
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (in_ready) begin
         valid_in = in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         hit_ff <= hit_in;
         for (int g = 0; g < GroupCount; g++) begin
            idx_ff[g] <= idx_in[g];
            val_ff[g] <= val_in[g];
         end
      end
   end

   assign out_valid = valid_ff;
   assign out_hit   = hit_ff;

   always_comb begin
      for (int g = 0; g < GroupCount; g++) begin
         out_idx[g] = idx_ff[g];
         out_val[g] = val_ff[g];
      end
   end

endmodule

[sv/frr_select.sv]
// ----------------------------------------------------------------------------
// Final select and output register
// Picks the first group that hit, applies the no-match policy and holds the
// result beat until the receiver takes it.
// ----------------------------------------------------------------------------
module frr_select #(
   parameter  int RULES      = frr_pkg::RULES_DEFAULT,
   localparam int GroupCount = (RULES + frr_pkg::GROUP_SIZE - 1) / frr_pkg::GROUP_SIZE
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 in_valid,
   output logic                                 in_ready,
   input  logic [GroupCount-1:0]                in_hit,
   input  logic [frr_pkg::GROUP_IDX_W-1:0]      in_idx [GroupCount],
   input  logic signed [frr_pkg::DATA_W-1:0]    in_val [GroupCount],
   input  logic                                 separate,
   output logic                                 out_valid,
   input  logic                                 out_ready,
   output frr_pkg::rsp_type                     out_data
);

   logic                               valid_ff, valid_in;
   frr_pkg::rsp_type                   rsp_ff, rsp_in;
   logic [GroupCount-1:0]              first_grp;
   logic [frr_pkg::GROUP_IDX_W-1:0]    sel_idx;
   logic signed [frr_pkg::DATA_W-1:0]  sel_val;
   logic                               any_hit, advance;

   assign in_ready = !valid_ff || out_ready;
   assign advance  = in_valid && in_ready;
   assign any_hit  = |in_hit;

   always_comb begin
      first_grp = in_hit & (~in_hit + GroupCount'(1));
      sel_idx   = '0;
      sel_val   = '0;
      for (int g = 0; g < GroupCount; g++) begin
         if (first_grp[g]) begin
            sel_idx = sel_idx | in_idx[g];
            sel_val = sel_val | in_val[g];
         end
      end
   end

   // Without a match, a separate destination receives system-missing and a
   // shared one is left untouched.
   always_comb begin
      rsp_in.matched      = any_hit;
      rsp_in.hit_rule     = any_hit ? sel_idx : '0;
      rsp_in.write_dest   = any_hit || separate;
      if (any_hit) begin
         rsp_in.result_value = sel_val;
      end else if (separate) begin
         rsp_in.result_value = frr_pkg::SYSMIS;
      end else begin
         rsp_in.result_value = '0;
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (in_ready) begin
         valid_in = in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = rsp_ff;

`ifndef SYNTH
   a_miss_index_zero : assert property (@(posedge clock) disable iff (reset)
      (valid_ff && !rsp_ff.matched) |-> (rsp_ff.hit_rule == '0))
      else $error("hit_rule is not zero on a miss");

   a_hit_writes : assert property (@(posedge clock) disable iff (reset)
      (valid_ff && rsp_ff.matched) |-> rsp_ff.write_dest)
      else $error("matched result does not write the destination");

   a_unwritten_zero : assert property (@(posedge clock) disable iff (reset)
      (valid_ff && !rsp_ff.write_dest) |-> (rsp_ff.result_value == '0))
      else $error("unwritten result carries a non-zero value");
`endif

endmodule

[sv/first_match_range_recode_top.sv]
// ----------------------------------------------------------------------------
// First-match range recoder: top level
// Rule table with ordered first-match search over one sample per beat.
// ----------------------------------------------------------------------------
// Usage:
//   The req_ channel carries two kinds of beat, selected by req_tuser. A rule
//   write stores one rule entry and gives no result. A recode beat searches
//   rules from entry zero up to the rule count and returns one rsp_ beat with
//   the first match's output, or the no-match policy of the csr registers.
//   A rule write takes effect for every recode beat accepted after it.
//   The csr_ port writes the rule count and the separate-destination flag;
//   users write it only while no beat is in flight; the block does not check.
//   After acceptance the beat passes the input register, the match stage over
//   all rules, the group resolve and the final select and output register in
//   turn before rsp_tvalid rises.
//   One beat is accepted every cycle while the receiver takes them.
//   When rsp_tready is low the stages fill one by one and req_tready falls
//   once every stage holds a beat; nothing is dropped or repeated.
//   Reset clears the valid bits and both registers; the rule table keeps its
//   contents and must be loaded before use.
// ----------------------------------------------------------------------------
module first_match_range_recode_top #(
   parameter int RULES = frr_pkg::RULES_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // rule_index, rule_kind, low_bound, high_bound, copy_sample, out_constant,
   // sample, is_user_missing, zero padding
   input  logic [frr_pkg::REQ_TDATA_W-1:0]       req_tdata,
   // action
   input  logic [0:0]                            req_tuser,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // result_value, write_dest, matched, hit_rule, zero padding
   output logic [frr_pkg::RSP_TDATA_W-1:0]       rsp_tdata,
   input  logic                                  csr_we,
   input  logic [frr_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [frr_pkg::CSR_DATA_W-1:0]        csr_wdata
);

   localparam int GroupCount = (RULES + frr_pkg::GROUP_SIZE - 1) / frr_pkg::GROUP_SIZE;

   logic [frr_pkg::COUNT_W-1:0]        rule_count_ff, rule_count_in;
   logic                               separate_ff, separate_in;
   logic                               s1_valid_ff, s1_valid_in;
   frr_pkg::req_type                   s1_data_ff, req_data;
   logic                               s1_ready;

   logic                               m_valid, m_ready;
   logic [RULES-1:0]                   m_match;
   logic signed [frr_pkg::DATA_W-1:0]  m_sample;
   logic                               copy_tab  [RULES];
   logic signed [frr_pkg::DATA_W-1:0]  const_tab [RULES];

   logic                               g_valid, g_ready;
   logic [GroupCount-1:0]              g_hit;
   logic [frr_pkg::GROUP_IDX_W-1:0]    g_idx [GroupCount];
   logic signed [frr_pkg::DATA_W-1:0]  g_val [GroupCount];

   frr_pkg::rsp_type                   rsp_data;

   always_comb begin
      rule_count_in = rule_count_ff;
      separate_in   = separate_ff;
      if (csr_we) begin
         case (frr_pkg::csr_index_type'(csr_index))
            frr_pkg::CSR_RULE_COUNT: rule_count_in = csr_wdata;
            frr_pkg::CSR_SEPARATE:   separate_in   = csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rule_count_ff <= '0;
         separate_ff   <= 1'b0;
      end else begin
         rule_count_ff <= rule_count_in;
         separate_ff   <= separate_in;
      end
   end

   always_comb begin
      req_data.action          = frr_pkg::action_type'(req_tuser[0]);
      req_data.rule_index      = req_tdata[3:0];
      req_data.rule_kind       = req_tdata[6:4];
      req_data.low_bound       = req_tdata[38:7];
      req_data.high_bound      = req_tdata[70:39];
      req_data.copy_sample     = req_tdata[71];
      req_data.out_constant    = req_tdata[103:72];
      req_data.sample          = req_tdata[135:104];
      req_data.is_user_missing = req_tdata[136];
   end

   assign req_tready = !s1_valid_ff || s1_ready;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_tready) begin
         s1_valid_in = req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         s1_data_ff <= req_data;
      end
   end

   frr_match #(.RULES(RULES)) u_match (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (s1_valid_ff),
      .in_ready   (s1_ready),
      .in_data    (s1_data_ff),
      .rule_count (rule_count_ff),
      .out_valid  (m_valid),
      .out_ready  (m_ready),
      .out_match  (m_match),
      .out_sample (m_sample),
      .copy_tab   (copy_tab),
      .const_tab  (const_tab)
   );

   frr_group #(.RULES(RULES)) u_group (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (m_valid),
      .in_ready  (m_ready),
      .in_match  (m_match),
      .in_sample (m_sample),
      .copy_tab  (copy_tab),
      .const_tab (const_tab),
      .out_valid (g_valid),
      .out_ready (g_ready),
      .out_hit   (g_hit),
      .out_idx   (g_idx),
      .out_val   (g_val)
   );

   frr_select #(.RULES(RULES)) u_select (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (g_valid),
      .in_ready  (g_ready),
      .in_hit    (g_hit),
      .in_idx    (g_idx),
      .in_val    (g_val),
      .separate  (separate_ff),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (rsp_data)
   );

   assign rsp_tdata = {2'b00, rsp_data.hit_rule, rsp_data.matched,
                       rsp_data.write_dest, rsp_data.result_value};

`ifndef SYNTH
   a_reset_no_result : assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result beat presented straight after reset");
`endif

endmodule
